// ===== src/nrecip_pkg.sv =====
// shared types and codes for the newton reciprocal block
`timescale 1ns / 1ps
`default_nettype none

package nrecip_pkg;

  typedef logic [1:0] status_t;

  localparam status_t STAT_CONV  = 2'd0;
  localparam status_t STAT_ZERO  = 2'd1;
  localparam status_t STAT_LIMIT = 2'd2;

  localparam int unsigned CFG_DATA_W = 5;

  localparam logic CFG_IDX_TOL = 1'b0;
  localparam logic CFG_IDX_LIM = 1'b1;

  localparam logic [4:0] TOL_RESET = 5'd24;
  localparam logic [3:0] LIM_RESET = 4'd8;

  typedef struct packed {
    logic    start;
    logic    lzc;
    logic    ksel;
    logic    pmul;
    logic    psh;
    logic    check;
    logic    tmul;
    logic    mupd;
    logic    load_out;
    status_t code;
  } nrecip_cmd_t;

  typedef struct packed {
    logic in_zero;
    logic conv;
    logic at_limit;
  } nrecip_sts_t;

endpackage

`default_nettype wire

// ===== src/nrecip_dp.sv =====
// datapath: normalization, shared multiplier, newton update and result register
`timescale 1ns / 1ps
`default_nettype none

module nrecip_dp #(
  parameter int FRAC_BITS = 30
) (
  input  logic                      clk,
  input  nrecip_pkg::nrecip_cmd_t   cmd,
  output nrecip_pkg::nrecip_sts_t   sts,
  input  logic [31:0]               in_operand_value,
  input  logic [4:0]                tol_shift,
  input  logic [3:0]                iter_limit,
  output logic [31:0]               out_recip_mantissa,
  output logic signed [5:0]         out_recip_exponent,
  output logic [3:0]                out_step_count,
  output nrecip_pkg::status_t       out_status
);
  import nrecip_pkg::*;

  localparam int MW  = FRAC_BITS + 2;
  localparam int PW  = FRAC_BITS + 3;
  localparam int OW  = (MW > 32) ? MW : 32;
  localparam int PRW = 2 * OW;

  localparam logic [PW-1:0]    ONE   = PW'(1) << FRAC_BITS;
  localparam logic [PW-1:0]    TWO   = PW'(1) << (FRAC_BITS + 1);
  localparam logic [MW+31:0]   MAX32 = (MW + 32)'(32'hFFFF_FFFF);
  localparam logic [5:0]       FB6   = 6'(FRAC_BITS);

  logic [31:0]        a_r;
  logic [4:0]         msb_r;
  logic signed [5:0]  k_r;
  logic [5:0]         sh_r;
  logic [MW-1:0]      m_r;
  logic [MW-1:0]      t_r;
  logic [PRW-1:0]     prod_r;
  logic [PW-1:0]      p_r;
  logic [PW-1:0]      lo_r;
  logic [PW-1:0]      hi_r;
  logic [3:0]         steps_r;
  logic [31:0]        out_mant_r;
  logic signed [5:0]  out_exp_r;
  logic [3:0]         out_steps_r;
  status_t            out_status_r;

  logic [4:0]     msb_nxt;
  logic [32:0]    lim;
  logic [5:0]     k_nxt;
  logic [PW-1:0]  eps;
  logic [OW-1:0]  mul_a;
  logic [OW-1:0]  mul_b;
  logic [PRW-1:0] p_shift;
  logic [PW-1:0]  p_nxt;
  logic [PRW-1:0] m_shift;
  logic [MW-1:0]  m_nxt;
  logic [MW-1:0]  t_nxt;
  logic [31:0]    mant_sat;

  // leading one position
  always_comb begin
    msb_nxt = '0;
    for (int i = 0; i < 32; i++) begin
      if (a_r[i]) begin
        msb_nxt = 5'(i);
      end
    end
  end

  // power of two choice
  always_comb begin
    lim = 33'd3 << (msb_r - 5'd1);
    if (a_r < 32'd32768) begin
      k_nxt = 6'd15 - {1'b0, msb_r};
    end else if (a_r > 32'd98304) begin
      if ({1'b0, a_r} <= lim) begin
        k_nxt = 6'd16 - {1'b0, msb_r};
      end else begin
        k_nxt = 6'd15 - {1'b0, msb_r};
      end
    end else begin
      k_nxt = '0;
    end
  end

  always_comb begin
    if ({1'b0, tol_shift} <= FB6) begin
      eps = ONE >> tol_shift;
    end else begin
      eps = '0;
    end
  end

  // shared multiplier operands
  always_comb begin
    if (cmd.tmul) begin
      mul_a = OW'(m_r);
      mul_b = OW'(t_r);
    end else begin
      mul_a = OW'(a_r);
      mul_b = OW'(m_r);
    end
  end

  always_comb begin
    p_shift = prod_r >> sh_r;
    p_nxt   = (|p_shift[PRW-1:PW]) ? '1 : p_shift[PW-1:0];
    m_shift = prod_r >> FRAC_BITS;
    m_nxt   = (|m_shift[PRW-1:MW]) ? '1 : m_shift[MW-1:0];
    t_nxt   = (p_r < TWO) ? MW'(TWO - p_r) : '0;
    mant_sat = ((MW + 32)'(m_r) > MAX32) ? 32'hFFFF_FFFF : 32'(m_r);
  end

  assign sts.in_zero  = (in_operand_value == 32'd0);
  assign sts.conv     = (p_r >= lo_r) && (p_r <= hi_r);
  assign sts.at_limit = (steps_r >= iter_limit);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_r     <= in_operand_value;
      m_r     <= '0;
      k_r     <= '0;
      steps_r <= '0;
    end
    if (cmd.lzc) begin
      msb_r <= msb_nxt;
      lo_r  <= ONE - eps;
      hi_r  <= ONE + eps;
    end
    if (cmd.ksel) begin
      k_r  <= k_nxt;
      sh_r <= 6'd16 - k_nxt;
      m_r  <= MW'(ONE);
    end
    if (cmd.pmul || cmd.tmul) begin
      prod_r <= PRW'(mul_a) * PRW'(mul_b);
    end
    if (cmd.psh) begin
      p_r <= p_nxt;
    end
    if (cmd.check) begin
      t_r <= t_nxt;
    end
    if (cmd.mupd) begin
      m_r     <= m_nxt;
      steps_r <= steps_r + 4'd1;
    end
    if (cmd.load_out) begin
      out_mant_r   <= mant_sat;
      out_exp_r    <= k_r;
      out_steps_r  <= steps_r;
      out_status_r <= cmd.code;
    end
  end

  assign out_recip_mantissa = out_mant_r;
  assign out_recip_exponent = out_exp_r;
  assign out_step_count     = out_steps_r;
  assign out_status         = out_status_r;

endmodule

`default_nettype wire

// ===== src/nrecip_ctrl.sv =====
// controller: sequences normalization and newton steps, owns the in and out handshakes
`timescale 1ns / 1ps
`default_nettype none

module nrecip_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  input  nrecip_pkg::nrecip_sts_t   sts,
  output nrecip_pkg::nrecip_cmd_t   cmd
);
  import nrecip_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LZC,
    S_KSEL,
    S_PMUL,
    S_PSH,
    S_CHECK,
    S_TMUL,
    S_MUPD,
    S_DONE
  } state_t;

  state_t  state_r;
  status_t code_r;
  logic    out_valid_r;
  logic    out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.code     = code_r;
    cmd.start    = (state_r == S_IDLE) && in_valid;
    cmd.lzc      = (state_r == S_LZC);
    cmd.ksel     = (state_r == S_KSEL);
    cmd.pmul     = (state_r == S_PMUL);
    cmd.psh      = (state_r == S_PSH);
    cmd.check    = (state_r == S_CHECK);
    cmd.tmul     = (state_r == S_TMUL);
    cmd.mupd     = (state_r == S_MUPD);
    cmd.load_out = (state_r == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      code_r      <= STAT_CONV;
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (sts.in_zero) begin
              code_r  <= STAT_ZERO;
              state_r <= S_DONE;
            end else begin
              state_r <= S_LZC;
            end
          end
        end
        S_LZC:  state_r <= S_KSEL;
        S_KSEL: state_r <= S_PMUL;
        S_PMUL: state_r <= S_PSH;
        S_PSH:  state_r <= S_CHECK;
        S_CHECK: begin
          priority if (sts.conv) begin
            code_r  <= STAT_CONV;
            state_r <= S_DONE;
          end else if (sts.at_limit) begin
            code_r  <= STAT_LIMIT;
            state_r <= S_DONE;
          end else begin
            state_r <= S_TMUL;
          end
        end
        S_TMUL: state_r <= S_MUPD;
        S_MUPD: state_r <= S_PMUL;
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/newton_reciprocal.sv =====
// top level: newton-raphson reciprocal of an unsigned q16.16 value
//
//   channel | direction | beat contents
//   in_     | in        | operand_value (q16.16)
//   out_    | out       | recip_mantissa, recip_exponent, step_count, status
//   cfg_    | in        | cfg_index (0 tolerance_shift, 1 iteration_limit), cfg_data
//
// a nonzero operand goes from its accepting beat through leading one detection and the
// power of two choice into newton steps, each two passes through the one shared
// multiplier plus shift, check and update states. a zero operand skips all of these.
// one operand is in flight at a time; the next is taken from the cycle after the
// result is loaded, also while the result register waits on out_ready.
// reset is synchronous, restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module newton_reciprocal #(
  parameter int FRAC_BITS = 30
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          in_operand_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_recip_mantissa,
  output logic signed [5:0]    out_recip_exponent,
  output logic [3:0]           out_step_count,
  output logic [1:0]           out_status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [4:0]           cfg_data
);
  import nrecip_pkg::*;

  logic [4:0]   tol_r;
  logic [3:0]   lim_r;
  nrecip_cmd_t  cmd;
  nrecip_sts_t  sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
      lim_r <= LIM_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IDX_TOL: tol_r <= cfg_data;
        CFG_IDX_LIM: lim_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  nrecip_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  nrecip_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk                (clk),
    .cmd                (cmd),
    .sts                (sts),
    .in_operand_value   (in_operand_value),
    .tol_shift          (tol_r),
    .iter_limit         (lim_r),
    .out_recip_mantissa (out_recip_mantissa),
    .out_recip_exponent (out_recip_exponent),
    .out_step_count     (out_step_count),
    .out_status         (out_status)
  );

endmodule

`default_nettype wire
